// File: hdl/cwqh_pkg.sv
// Shared types and constants for the coalescing write queue with hold-off.
`default_nettype none
package cwqh_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 8;
  localparam logic [7:0]  HOLDOFF_RESET   = 8'd60;

  // Command queue between front and back; depth must be a power of two.
  localparam int unsigned CMDQ_DEPTH = 2;

  localparam logic OP_SCHEDULE = 1'b0;
  localparam logic OP_TICK     = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] item_id;
  } item_t;

  typedef struct packed {
    logic [7:0] flush_id;
    logic       last_of_flush;
  } result_t;

  typedef struct packed {
    logic       is_tick;
    logic [7:0] id;
  } cmd_t;

endpackage
`default_nettype wire

// File: hdl/cwqh_front.sv
// Front end: accepts items, decodes them and buffers them as commands.
`default_nettype none
module cwqh_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire cwqh_pkg::item_t item,
  output logic               cmd_valid,
  input  wire logic          cmd_pop,
  output cwqh_pkg::cmd_t     cmd
);

  localparam int unsigned PW = (cwqh_pkg::CMDQ_DEPTH > 1) ? $clog2(cwqh_pkg::CMDQ_DEPTH) : 1;
  localparam int unsigned FW = $clog2(cwqh_pkg::CMDQ_DEPTH + 1);
  localparam logic [FW-1:0] FULL_FILL = FW'(cwqh_pkg::CMDQ_DEPTH);

  cwqh_pkg::cmd_t  slots [cwqh_pkg::CMDQ_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [FW-1:0]   fill;
  logic            do_push;
  logic            do_pop;
  cwqh_pkg::cmd_t  decoded;

  assign full      = (fill == FULL_FILL);
  assign cmd_valid = (fill != '0);
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;
  assign cmd       = slots[rd_ptr];

  // Classify: ticks carry no identifier.
  always_comb begin
    decoded.is_tick = (item.opcode == cwqh_pkg::OP_TICK);
    decoded.id      = decoded.is_tick ? 8'd0 : item.item_id;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + FW'(1);
        2'b01:   fill <= fill - FW'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hdl/cwqh_back.sv
// Back end: pending-id queue, dedupe scan, hold-off timer and flush sequencer.
`default_nettype none
module cwqh_back #(
  parameter int unsigned QUEUE_DEPTH = cwqh_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [7:0]      holdoff_ticks,
  input  wire logic            cmd_valid,
  output logic                 cmd_pop,
  input  wire cwqh_pkg::cmd_t  cmd,
  output logic                 empty,
  input  wire logic            pop,
  output cwqh_pkg::result_t    result
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t          state, state_next;
  logic [CW-1:0]   count, count_next;
  logic [7:0]      timer, timer_next;
  logic [AW-1:0]   idx, idx_next;
  logic [7:0]      id_reg, id_reg_next;

  logic [7:0]      ids_mem [QUEUE_DEPTH];
  logic [7:0]      rd_data;
  logic [AW-1:0]   rd_addr;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [7:0]      mem_wdata;

  logic            out_valid;
  cwqh_pkg::result_t out_data;
  logic            out_load;
  logic            at_last;

  assign empty  = !out_valid;
  assign result = out_data;
  assign at_last = ((CW'(idx) + CW'(1)) == count);

  always_comb begin
    state_next  = state;
    count_next  = count;
    timer_next  = timer;
    idx_next    = idx;
    id_reg_next = id_reg;
    cmd_pop     = 1'b0;
    rd_addr     = '0;
    mem_we      = 1'b0;
    mem_waddr   = count[AW-1:0];
    mem_wdata   = id_reg;
    out_load    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop  = 1'b1;
          idx_next = '0;
          if (cmd.is_tick) begin
            if (timer != 8'd0) begin
              timer_next = timer - 8'd1;
              if (timer == 8'd1 && count != '0) begin
                state_next = ST_FLUSH;
              end
            end
          end else if (count == '0) begin
            mem_we     = 1'b1;
            mem_waddr  = '0;
            mem_wdata  = cmd.id;
            count_next = CW'(1);
            timer_next = holdoff_ticks;
          end else begin
            id_reg_next = cmd.id;
            state_next  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // rd_data holds entry idx
        rd_addr = idx + AW'(1);
        if (rd_data == id_reg) begin
          timer_next = holdoff_ticks;
          state_next = ST_IDLE;
        end else if (at_last) begin
          if (count != FULL_COUNT) begin
            mem_we     = 1'b1;
            count_next = count + CW'(1);
            timer_next = holdoff_ticks;
          end
          state_next = ST_IDLE;
        end else begin
          idx_next = idx + AW'(1);
        end
      end
      ST_FLUSH: begin
        out_load = !out_valid || pop;
        rd_addr  = out_load ? idx + AW'(1) : idx;
        if (out_load) begin
          if (at_last) begin
            count_next = '0;
            state_next = ST_IDLE;
          end else begin
            idx_next = idx + AW'(1);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ids_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= ids_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.flush_id      <= rd_data;
      out_data.last_of_flush <= at_last;
    end
    idx    <= idx_next;
    id_reg <= id_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      timer     <= 8'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      timer <= timer_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/coalescing_write_queue_holdoff_unit.sv
// Top level of the coalescing write queue with hold-off timer.
//
// Input channel (push/full): each item is a schedule request for item_id
// or one timer tick. Items land in a two-entry command queue, so the
// input side keeps moving while the back end scans or flushes.
// Result channel (empty/pop): one transfer per flushed identifier, in
// insertion order, last_of_flush set on the final one of a run.
// Config channel (cfg_valid/cfg_ready): always ready; sets holdoff_ticks.
//
// Back end per command: a tick is handled in the idle state; a schedule
// into an empty queue is written there directly, else it enters the scan
// state, one queue entry compared per cycle through the id memory's single
// read port. On the expiring tick the state moves to flush, which then
// moves one identifier per cycle into the registered result while the receiver pops.
// If the receiver stalls, the flush holds on the current entry and the
// input side keeps accepting until the command queue fills.
// Reset (synchronous, rst high): queue empty, timer idle, hold-off 60,
// no result pending. No clearing pass is needed: the fill count bounds
// every read of the id memory.
`default_nettype none
module coalescing_write_queue_holdoff_unit #(
  parameter int unsigned QUEUE_DEPTH = cwqh_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire cwqh_pkg::item_t   item,
  output logic                   empty,
  input  wire logic              pop,
  output cwqh_pkg::result_t      result,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [7:0]        cfg_data
);

  logic [7:0]     holdoff_ticks;
  logic           cmd_valid;
  logic           cmd_pop;
  cwqh_pkg::cmd_t cmd;

  // The user must send config writes only while idle; the block itself does not enforce this and gives no backpressure.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      holdoff_ticks <= cwqh_pkg::HOLDOFF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      holdoff_ticks <= cfg_data;
    end
  end

  cwqh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  cwqh_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .holdoff_ticks (holdoff_ticks),
    .cmd_valid     (cmd_valid),
    .cmd_pop       (cmd_pop),
    .cmd           (cmd),
    .empty         (empty),
    .pop           (pop),
    .result        (result)
  );

endmodule
`default_nettype wire
